// ===== src/llsa_pkg.sv =====
// ----------------------------------------------------------------------------
// llsa_pkg
// Shared constants and controller/datapath interface types for the
// least loaded server assignment block.
// ----------------------------------------------------------------------------
`default_nettype none

package llsa_pkg;

    localparam int MAX_SERVERS_DEF = 64;
    localparam int LOAD_BITS_DEF   = 32;

    localparam int SVC_W  = 16;
    localparam int SRV_W  = 7;
    localparam int OUT_TDATA_W = 16;

    typedef struct packed {
        logic job_load;
        logic cnt_clr;
        logic cnt_inc;
        logic clr_wr;
        logic rd;
        logic upd;
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_last_mem;
        logic cnt_last_scan;
        logic out_busy;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== src/llsa_ram.sv =====
// ----------------------------------------------------------------------------
// llsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module llsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire                             i_clk,
    input  wire                             i_we,
    input  wire [$clog2(DEPTH)-1:0]         i_waddr,
    input  wire [WIDTH-1:0]                 i_wdata,
    input  wire                             i_re,
    input  wire [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/llsa_dp.sv =====
// ----------------------------------------------------------------------------
// llsa_dp
// Datapath: load memory, address counter, min/second-min scan, saturating
// update, server count register and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module llsa_dp #(
    parameter int MAX_SERVERS = llsa_pkg::MAX_SERVERS_DEF,
    parameter int LOAD_BITS   = llsa_pkg::LOAD_BITS_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire llsa_pkg::t_dp_cmd          i_cmd,
    output llsa_pkg::t_dp_sts               o_sts,
    input  wire                             i_cfg_valid,
    input  wire [llsa_pkg::SRV_W-1:0]       i_cfg_data,
    input  wire [llsa_pkg::SVC_W-1:0]       i_svc,
    input  wire                             i_last,
    output logic                            o_out_valid,
    input  wire                             i_out_ready,
    output logic [llsa_pkg::SRV_W-1:0]      o_asg,
    output logic [llsa_pkg::SRV_W-1:0]      o_nxt,
    output logic                            o_out_last
);

    import llsa_pkg::*;

    localparam int AW = $clog2(MAX_SERVERS);
    localparam int CW = $clog2(MAX_SERVERS + 1);
    localparam int EW = (CW > SRV_W) ? CW : SRV_W;
    localparam int LW = LOAD_BITS;

    logic [SRV_W-1:0]  r_active;
    logic [AW-1:0]     r_addr;
    logic [AW-1:0]     r_last_idx;
    logic [SVC_W-1:0]  r_svc;
    logic              r_last;
    logic              r_rd_vld;
    logic [AW-1:0]     r_rd_idx;
    logic [LW-1:0]     r_best;
    logic [AW-1:0]     r_bi;
    logic [LW-1:0]     r_sec;
    logic [AW-1:0]     r_si;
    logic              r_sec_vld;
    logic              r_out_valid;
    logic [SRV_W-1:0]  r_out_asg;
    logic [SRV_W-1:0]  r_out_nxt;
    logic              r_out_last;

    logic [EW-1:0]     w_act;
    logic [EW-1:0]     w_cnt;
    logic [LW-1:0]     w_rdata;
    logic [LW:0]       w_sum;
    logic [LW-1:0]     w_upd;
    logic [AW-1:0]     w_nxt_idx;
    logic [AW:0]       w_asg_p1;
    logic [AW:0]       w_nxt_p1;
    logic [AW-1:0]     w_waddr;
    logic [LW-1:0]     w_wdata;

    // clamp the configured count to 1..MAX_SERVERS
    always_comb begin
        w_act = EW'(r_active);
        if (w_act == '0) begin
            w_cnt = EW'(1);
        end else if (w_act > EW'(MAX_SERVERS)) begin
            w_cnt = EW'(MAX_SERVERS);
        end else begin
            w_cnt = w_act;
        end
    end

    always_comb begin
        w_sum = {1'b0, r_best} + (LW + 1)'(r_svc);
        w_upd = w_sum[LW] ? '1 : w_sum[LW-1:0];
    end

    always_comb begin
        w_nxt_idx = r_bi;
        if (r_sec_vld) begin
            if (r_sec < w_upd) begin
                w_nxt_idx = r_si;
            end else if (r_sec == w_upd && r_si < r_bi) begin
                w_nxt_idx = r_si;
            end
        end
        w_asg_p1 = {1'b0, r_bi} + (AW + 1)'(1);
        w_nxt_p1 = {1'b0, w_nxt_idx} + (AW + 1)'(1);
    end

    assign w_waddr = i_cmd.clr_wr ? r_addr : r_bi;
    assign w_wdata = i_cmd.clr_wr ? '0 : w_upd;

    llsa_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_SERVERS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.clr_wr | i_cmd.upd),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= SRV_W'(1);
            r_addr      <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_active <= i_cfg_data;
            end
            if (i_cmd.cnt_clr) begin
                r_addr <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_addr <= r_addr + AW'(1);
            end
            r_rd_vld <= i_cmd.rd;
            if (i_cmd.upd) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.job_load) begin
            r_svc      <= i_svc;
            r_last     <= i_last;
            r_last_idx <= AW'(w_cnt - EW'(1));
        end
        r_rd_idx <= r_addr;
        if (r_rd_vld) begin
            if (r_rd_idx == '0) begin
                r_best    <= w_rdata;
                r_bi      <= '0;
                r_sec_vld <= 1'b0;
            end else if (w_rdata < r_best) begin
                r_sec     <= r_best;
                r_si      <= r_bi;
                r_sec_vld <= 1'b1;
                r_best    <= w_rdata;
                r_bi      <= r_rd_idx;
            end else if (!r_sec_vld || w_rdata < r_sec) begin
                r_sec     <= w_rdata;
                r_si      <= r_rd_idx;
                r_sec_vld <= 1'b1;
            end
        end
        if (i_cmd.upd) begin
            r_out_asg  <= SRV_W'(w_asg_p1);
            r_out_nxt  <= SRV_W'(w_nxt_p1);
            r_out_last <= r_last;
        end
    end

    assign o_sts.cnt_last_mem  = (r_addr == AW'(MAX_SERVERS - 1));
    assign o_sts.cnt_last_scan = (r_addr == r_last_idx);
    assign o_sts.out_busy      = r_out_valid & ~i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_asg       = r_out_asg;
    assign o_nxt       = r_out_nxt;
    assign o_out_last  = r_out_last;

endmodule

`default_nettype wire

// ===== src/llsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// llsa_ctrl
// Controller: sequences the clearing pass (after reset and for new-case jobs),
// the load scan and the update for each job.
// ----------------------------------------------------------------------------
`default_nettype none

module llsa_ctrl (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    input  wire                     i_in_new,
    output logic                    o_in_ready,
    output llsa_pkg::t_dp_cmd       o_cmd,
    input  wire llsa_pkg::t_dp_sts  i_sts
);

    import llsa_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_UPD   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_job;
    logic       n_job;

    always_comb begin
        n_state    = r_state;
        n_job      = r_job;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr  = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                if (i_sts.cnt_last_mem) begin
                    o_cmd.cnt_clr = 1'b1;
                    n_state = r_job ? S_SCAN : S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.job_load = 1'b1;
                    o_cmd.cnt_clr  = 1'b1;
                    n_job   = 1'b1;
                    n_state = i_in_new ? S_CLEAR : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd      = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                if (i_sts.cnt_last_scan) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (!i_sts.out_busy) begin
                    o_cmd.upd = 1'b1;
                    n_job   = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_job   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_job   <= n_job;
        end
    end

endmodule

`default_nettype wire

// ===== src/least_loaded_server_assign_top.sv =====
// ----------------------------------------------------------------------------
// least_loaded_server_assign_top
// Assigns each job to the least loaded server and reports the next pick.
// ----------------------------------------------------------------------------
// The loads sit in a single-port-read RAM; for each job the active servers
// are scanned one entry per cycle, then the chosen entry is written back. A
// job with the new-case flag first runs a clearing pass over all MAX_SERVERS
// entries of the load RAM; the same pass runs after reset, during which no
// job is accepted. A finished result waits in an output register while the
// next job is taken; the next write-back holds until that register is free.
`default_nettype none

module least_loaded_server_assign_top #(
    parameter int MAX_SERVERS = llsa_pkg::MAX_SERVERS_DEF,
    parameter int LOAD_BITS   = llsa_pkg::LOAD_BITS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire [llsa_pkg::SRV_W-1:0]           i_cfg_data,      // active_servers
    input  wire                                 i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  wire [llsa_pkg::SVC_W-1:0]           i_s_axis_tdata,  // service_time
    input  wire                                 i_s_axis_tuser,  // new_case
    input  wire                                 i_s_axis_tlast,  // last_job
    output logic                                o_m_axis_tvalid,
    input  wire                                 i_m_axis_tready,
    output logic [llsa_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,  // assigned_server,
                                                                 // next_server, pad
    output logic                                o_m_axis_tlast   // case_done
);

    import llsa_pkg::*;

    t_dp_cmd          w_cmd;
    t_dp_sts          w_sts;
    logic [SRV_W-1:0] w_asg;
    logic [SRV_W-1:0] w_nxt;

    assign o_cfg_ready = 1'b1;

    llsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_new   (i_s_axis_tuser),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    llsa_dp #(
        .MAX_SERVERS (MAX_SERVERS),
        .LOAD_BITS   (LOAD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_svc       (i_s_axis_tdata),
        .i_last      (i_s_axis_tlast),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_asg       (w_asg),
        .o_nxt       (w_nxt),
        .o_out_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {(OUT_TDATA_W - 2 * SRV_W)'(0), w_nxt, w_asg};

endmodule

`default_nettype wire

// ===== tb/sv/least_loaded_server_assign_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// least_loaded_server_assign_top_tb
// Drives job transfers into the least loaded server assignment block and
// checks each assignment against a cycle-free model of the per-server loads.
// Covers server-count extremes and out-of-range counts, count changes inside a
// case, new-case clears, and random case streams under sender and receiver
// stalls, a long output hold-off and full drains.
// ----------------------------------------------------------------------------
`default_nettype none

module least_loaded_server_assign_top_tb;

    import llsa_pkg::*;

    localparam int NUM_SERVERS = MAX_SERVERS_DEF;
    localparam int LOAD_W      = LOAD_BITS_DEF;
    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int PRINT_CAP   = 100;

    typedef struct packed {
        logic [SRV_W-1:0] assigned;
        logic [SRV_W-1:0] next_pick;
        logic             done;
    } t_server_pick;

    class server_load_book;
        logic [LOAD_W-1:0] loads [NUM_SERVERS];
        logic [SRV_W-1:0]  servers;
        t_server_pick      pending_picks [$];
        int unsigned       errors;
        int unsigned       jobs_seen;
        int unsigned       picks_checked;
        int unsigned       answers;
        int unsigned       clamps;
        int unsigned       count_writes;

        function new();
            foreach (loads[i]) loads[i] = '0;
            servers       = 7'd1;
            errors        = 0;
            jobs_seen     = 0;
            picks_checked = 0;
            answers       = 0;
            clamps        = 0;
            count_writes  = 0;
        endfunction

        function void set_servers(logic [SRV_W-1:0] value);
            servers = value;
            count_writes++;
        endfunction

        function int unsigned least_loaded(int unsigned n);
            int unsigned best;
            best = 0;
            for (int unsigned i = 1; i < n; i++) begin
                if (loads[i] < loads[best]) best = i;
            end
            return best;
        endfunction

        function void note_job(logic [SVC_W-1:0] svc, logic fresh, logic last);
            localparam logic [LOAD_W-1:0] LOAD_MAX = '1;
            int unsigned  n;
            int unsigned  pick;
            t_server_pick want;
            n = (servers == 0) ? 1 : (servers > NUM_SERVERS) ? NUM_SERVERS : servers;
            if (fresh) begin
                foreach (loads[i]) loads[i] = '0;
            end
            pick = least_loaded(n);
            if (loads[pick] > LOAD_MAX - LOAD_W'(svc)) begin
                loads[pick] = LOAD_MAX;
                clamps++;
            end else begin
                loads[pick] = loads[pick] + LOAD_W'(svc);
            end
            want.assigned  = SRV_W'(pick + 1);
            want.next_pick = SRV_W'(least_loaded(n) + 1);
            want.done      = last;
            pending_picks.push_back(want);
            jobs_seen++;
            if (last) answers++;
        endfunction

        task report_mismatch(string field, logic [15:0] got, logic [15:0] want);
            errors++;
            if (errors <= PRINT_CAP) begin
                $display("[%0t] result %0d: %s got %0d expected %0d",
                         $realtime, picks_checked, field, got, want);
            end
        endtask

        task check_assignment(logic [OUT_TDATA_W-1:0] data, logic done);
            t_server_pick want;
            if (pending_picks.size() == 0) begin
                report_mismatch("result with no job pending", data, '0);
                return;
            end
            want = pending_picks.pop_front();
            if (data[SRV_W-1:0] !== want.assigned)
                report_mismatch("assigned_server", 16'(data[SRV_W-1:0]), 16'(want.assigned));
            if (data[2*SRV_W-1:SRV_W] !== want.next_pick)
                report_mismatch("next_server", 16'(data[2*SRV_W-1:SRV_W]),
                                16'(want.next_pick));
            if (data[OUT_TDATA_W-1:2*SRV_W] !== '0)
                report_mismatch("pad bits", 16'(data[OUT_TDATA_W-1:2*SRV_W]), '0);
            if (done !== want.done)
                report_mismatch("case_done", 16'(done), 16'(want.done));
            picks_checked++;
        endtask
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [SRV_W-1:0]       i_cfg_data;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [SVC_W-1:0]       i_s_axis_tdata;
    logic                   i_s_axis_tuser;
    logic                   i_s_axis_tlast;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tlast;

    server_load_book board;
    int unsigned     send_idle_pct;
    int unsigned     recv_idle_pct;
    int unsigned     hold_cycles;
    int unsigned     cycles;

    least_loaded_server_assign_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("cycle limit reached with %0d results outstanding",
                 board.pending_picks.size());
        $display("least_loaded_server_assign_top test failed");
        $finish;
    end

    // Receiver: hold off while a hold count is pending, else stall at random.
    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_m_axis_tready <= 1'b0;
                hold_cycles--;
            end else begin
                i_m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                board.set_servers(i_cfg_data);
            if (i_s_axis_tvalid && o_s_axis_tready)
                board.note_job(i_s_axis_tdata, i_s_axis_tuser, i_s_axis_tlast);
            if (o_m_axis_tvalid && i_m_axis_tready)
                board.check_assignment(o_m_axis_tdata, o_m_axis_tlast);
        end
    end

    task automatic send_job(input logic [SVC_W-1:0] svc, input logic fresh,
                            input logic last);
        @(negedge i_clk);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= svc;
        i_s_axis_tuser  <= fresh;
        i_s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (board.pending_picks.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_servers(input logic [SRV_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [SVC_W-1:0] rand_service();
        case ($urandom_range(9, 0))
            0:       return '1;
            1, 2:    return SVC_W'($urandom_range(3, 0));
            3:       return SVC_W'($urandom_range(255, 0));
            default: return SVC_W'($urandom);
        endcase
    endfunction

    // Mostly small server counts; the first two phases pin the extremes.
    function automatic logic [SRV_W-1:0] pick_server_count(int phase);
        if (phase == 0) return SRV_W'(NUM_SERVERS);
        if (phase == 1) return 7'd1;
        case ($urandom_range(19, 0))
            0:       return 7'd0;
            1:       return SRV_W'($urandom_range(127, NUM_SERVERS + 1));
            2, 3:    return SRV_W'($urandom_range(NUM_SERVERS, 9));
            default: return SRV_W'($urandom_range(8, 2));
        endcase
    endfunction

    task automatic run_phase(input int unsigned jobs, input int unsigned hold,
                             input bit pause_mid);
        int unsigned left;
        int unsigned run_len;
        logic        fresh;
        logic        last;
        left        = jobs;
        hold_cycles = hold;
        while (left > 0) begin
            run_len = $urandom_range(12, 1);
            if (run_len > left) run_len = left;
            for (int unsigned k = 0; k < run_len; k++) begin
                fresh = (k == 0) && ($urandom_range(9, 0) != 0);
                last  = (k == run_len - 1);
                if ($urandom_range(9, 0) == 0) begin
                    fresh = 1'($urandom_range(1, 0));
                    last  = 1'($urandom_range(1, 0));
                end
                send_job(rand_service(), fresh, last);
            end
            left -= run_len;
            if (pause_mid && left <= jobs / 2) begin
                wait_drained();
                pause_mid = 1'b0;
            end
        end
    endtask

    initial begin
        board           = new();
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        hold_cycles     = 0;
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = 1'b0;
        i_s_axis_tlast  = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: single server from reset, then bit patterns over four servers.
        send_job(16'h0000, 1'b1, 1'b0);
        send_job(16'hFFFF, 1'b0, 1'b1);
        wait_drained();
        write_servers(7'd4);
        send_job(16'h0000, 1'b1, 1'b0);
        send_job(16'hFFFF, 1'b0, 1'b0);
        send_job(16'h0001, 1'b0, 1'b0);
        send_job(16'h8000, 1'b0, 1'b0);
        send_job(16'h7FFF, 1'b0, 1'b0);
        send_job(16'hAAAA, 1'b0, 1'b0);
        send_job(16'h5555, 1'b0, 1'b0);
        // Shrink the count inside a case, then widen it again.
        wait_drained();
        write_servers(7'd2);
        send_job(16'h0003, 1'b0, 1'b0);
        send_job(16'h0005, 1'b0, 1'b0);
        wait_drained();
        write_servers(7'd4);
        send_job(16'h0001, 1'b0, 1'b1);
        wait_drained();
        write_servers(7'd0);
        send_job(16'd10, 1'b1, 1'b0);
        send_job(16'd20, 1'b0, 1'b1);
        wait_drained();
        write_servers(7'd127);
        send_job(16'h0000, 1'b1, 1'b0);
        send_job(16'h0007, 1'b0, 1'b0);
        send_job(16'h0000, 1'b0, 1'b1);
        wait_drained();
        write_servers(7'd65);
        send_job(16'h0001, 1'b1, 1'b1);

        // Load server 1 heavily, then compare it against a fresh server 2.
        wait_drained();
        write_servers(7'd1);
        send_job(16'hFFFF, 1'b1, 1'b0);
        send_job(16'h0000, 1'b0, 1'b1);
        wait_drained();
        write_servers(7'd2);
        send_job(rand_service(), 1'b0, 1'b0);
        send_job(16'hFFFF, 1'b0, 1'b0);
        send_job(rand_service(), 1'b0, 1'b1);
        wait_drained();
        write_servers(7'd1);
        send_job(16'h1234, 1'b0, 1'b1);

        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 18 : (mode == 1) ? 85 : 0;
            recv_idle_pct = (mode == 0) ? 85 : (mode == 1) ? 18 : 0;
            for (int ph = 0; ph < 6; ph++) begin
                wait_drained();
                write_servers(pick_server_count(ph));
                run_phase(53, (ph == 2) ? 400 : 0, ph[0]);
            end
        end

        wait_drained();
        repeat (2 * NUM_SERVERS + 8) @(posedge i_clk);
        $display("Checked %0d assignments from %0d jobs, %0d case answers, %0d count writes.",
                 board.picks_checked, board.jobs_seen, board.answers, board.count_writes);
        $display("Saturated load updates: %0d; stalls, a long output hold-off and drains hit.",
                 board.clamps);
        if (board.errors == 0 && board.pending_picks.size() == 0) begin
            $display("least_loaded_server_assign_top test passed");
        end else begin
            $display("least_loaded_server_assign_top test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/llsa_pkg.sv
src/llsa_ram.sv
src/llsa_dp.sv
src/llsa_ctrl.sv
src/least_loaded_server_assign_top.sv
tb/sv/least_loaded_server_assign_top_tb.sv
